@@ rtl/core/assert_macros.svh @@
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on clk.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every edge outside reset
`define LSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every edge, reset included
`define LSP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/lsp_pkg.sv @@
// ------------------------------------------------------------------------
// lsp_pkg
// Types, codes and helpers shared by the log sentence parser modules.
// ------------------------------------------------------------------------
package lsp_pkg;

  localparam logic [7:0] MAX_DATA_BYTES = 8'd223;

  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Parser phase, one-hot
  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_TIME   = 9'b000000010,
    PH_GROUP  = 9'b000000100,
    PH_SRC_HI = 9'b000001000,
    PH_SRC_LO = 9'b000010000,
    PH_SKIP   = 9'b000100000,
    PH_DATA   = 9'b001000000,
    PH_CK_HI  = 9'b010000000,
    PH_CK_LO  = 9'b100000000
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_AT   = 3'd1,
    ST_BAD_HEX = 3'd2,
    ST_ODD     = 3'd3,
    ST_LONG    = 3'd4,
    ST_CKSUM   = 3'd5,
    ST_TRUNC   = 3'd6
  } status_t;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_FINAL = 1'b1
  } kind_t;

  // One result item as it travels through the queue
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [31:0] time_value;
    logic [31:0] group_number;
    logic [7:0]  sender;
    logic [7:0]  payload_length;
    status_t     status;
  } result_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // Decode one ASCII hex digit, either case
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= 8'd48 && c <= 8'd57) begin
      h.valid = 1'b1;
      h.value = 4'(c - 8'd48);
    end else if (c >= 8'd65 && c <= 8'd70) begin
      h.valid = 1'b1;
      h.value = 4'(c - 8'd55);
    end else if (c >= 8'd97 && c <= 8'd102) begin
      h.valid = 1'b1;
      h.value = 4'(c - 8'd87);
    end
    return h;
  endfunction

endpackage

@@ rtl/core/log_sentence_parser.sv @@
// ------------------------------------------------------------------------
// log_sentence_parser
// Parses @millis,PGN,source,hexdata*checksum lines one character a cycle while the result queue has room.
// ------------------------------------------------------------------------
// Input stream: one character per transaction on s_tdata, with s_tuser set
// on the first character of each line. Output stream: one transaction per
// decoded data byte (m_tuser low) and one end-of-line record (m_tuser high)
// carrying the timestamp, group number, sender, byte count and status.
// Throughput is one character per cycle while the result queue is not full;
// the parser updates its state for every character it takes. The parser
// writes a result into a four-entry result queue at the edge that takes
// its character; the result then moves into the output register, which
// drives m_tvalid, once that register is empty or being drained.
// When the receiver stalls, results collect in the queue and s_tready
// drops only once the queue is full. Reset clears the parser to wait for
// a line start and empties the queue and the output register.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module log_sentence_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] character
  input  logic         s_tuser,   // [0] line_start
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] data_byte, [15:8] byte_index, [47:16] time_value,
  // [79:48] group_number, [87:80] sender, [95:88] payload_length,
  // [98:96] status, [103:99] zero
  output logic [103:0] m_tdata,
  output logic         m_tuser    // [0] kind
);

  logic               push;
  logic               pop;
  lsp_pkg::result_t   push_data;
  lsp_pkg::result_t   pop_data;
  lsp_pkg::q_status_t q_stat;

  lsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .character  (s_tdata),
    .line_start (s_tuser),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  lsp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  lsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

  // Never push into a full queue
  `LSP_ASSERT(a_no_overflow, q_stat.full |-> !push, "push into full result queue")

  // Never pop an empty queue
  `LSP_ASSERT(a_no_underflow, q_stat.empty |-> !pop, "pop from empty result queue")

  // Data bytes carry ok status and a length one past their index
  `LSP_ASSERT(a_data_fields,
    (m_tvalid && (m_tuser == lsp_pkg::KIND_DATA)) |->
      ((m_tdata[98:96] == lsp_pkg::ST_OK) && (m_tdata[95:88] == m_tdata[15:8] + 8'd1)),
    "data byte result with inconsistent fields")

  // Output register is empty straight after reset
  `LSP_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid,
    "output valid straight after reset")

endmodule

@@ rtl/core/lsp_front.sv @@
// ------------------------------------------------------------------------
// lsp_front
// Character parser: takes one character a cycle unless the queue is full,
// tracks sentence fields and queues data bytes and end-of-line records.
// ------------------------------------------------------------------------
module lsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          character,
  input  logic                line_start,
  input  lsp_pkg::q_status_t  q_stat,
  output logic                push,
  output lsp_pkg::result_t    push_data
);

  lsp_pkg::phase_t phase, phase_next;
  logic [31:0] time_accum, time_accum_next;
  logic [31:0] group_accum, group_accum_next;
  logic [7:0]  sender_reg, sender_reg_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic        nibble_pending, nibble_pending_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  running_xor, running_xor_next;

  logic         accept;
  lsp_pkg::hex_t hv;
  logic         fin;
  lsp_pkg::status_t fin_status;
  logic [7:0]   ck_byte;
  logic [7:0]   new_byte;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign hv       = lsp_pkg::hex_decode(character);
  assign ck_byte  = {high_nibble, hv.value};
  assign new_byte = {high_nibble, hv.value};

  // Work out the next parser state and any result for this character
  always_comb begin
    phase_next          = phase;
    time_accum_next     = time_accum;
    group_accum_next    = group_accum;
    sender_reg_next     = sender_reg;
    high_nibble_next    = high_nibble;
    nibble_pending_next = nibble_pending;
    byte_count_next     = byte_count;
    running_xor_next    = running_xor;
    fin                 = 1'b0;
    fin_status          = lsp_pkg::ST_OK;
    push                = 1'b0;
    push_data           = '0;

    if (accept) begin
      if (line_start) begin
        // Restart the line; anything half parsed is dropped
        time_accum_next     = '0;
        group_accum_next    = '0;
        sender_reg_next     = '0;
        high_nibble_next    = '0;
        nibble_pending_next = 1'b0;
        byte_count_next     = '0;
        running_xor_next    = '0;
        if (character != lsp_pkg::CH_AT) begin
          phase_next        = lsp_pkg::PH_IDLE;
          push              = 1'b1;
          push_data.kind    = lsp_pkg::KIND_FINAL;
          push_data.status  = lsp_pkg::ST_NO_AT;
        end else begin
          phase_next = lsp_pkg::PH_TIME;
        end
      end else if (phase == lsp_pkg::PH_IDLE) begin
        phase_next = lsp_pkg::PH_IDLE;
      end else if (character == lsp_pkg::CH_NUL) begin
        fin        = 1'b1;
        fin_status = lsp_pkg::ST_TRUNC;
      end else begin
        // Fold every character after the @ up to the star into the checksum
        if ((phase == lsp_pkg::PH_TIME) || (phase == lsp_pkg::PH_GROUP) ||
            (phase == lsp_pkg::PH_SRC_HI) || (phase == lsp_pkg::PH_SRC_LO) ||
            (phase == lsp_pkg::PH_SKIP) ||
            ((phase == lsp_pkg::PH_DATA) && (character != lsp_pkg::CH_STAR))) begin
          running_xor_next = running_xor ^ character;
        end

        unique case (phase)
          lsp_pkg::PH_TIME: begin
            if (character == lsp_pkg::CH_COMMA) phase_next = lsp_pkg::PH_GROUP;
            else time_accum_next = time_accum * 32'd10 + {24'd0, character}
                                   - {24'd0, lsp_pkg::CH_ZERO};
          end
          lsp_pkg::PH_GROUP: begin
            if (character == lsp_pkg::CH_COMMA) phase_next = lsp_pkg::PH_SRC_HI;
            else group_accum_next = group_accum * 32'd10 + {24'd0, character}
                                    - {24'd0, lsp_pkg::CH_ZERO};
          end
          lsp_pkg::PH_SRC_HI: begin
            if (!hv.valid) begin
              fin        = 1'b1;
              fin_status = lsp_pkg::ST_BAD_HEX;
            end else begin
              high_nibble_next = hv.value;
              phase_next       = lsp_pkg::PH_SRC_LO;
            end
          end
          lsp_pkg::PH_SRC_LO: begin
            if (!hv.valid) begin
              fin        = 1'b1;
              fin_status = lsp_pkg::ST_BAD_HEX;
            end else begin
              sender_reg_next = new_byte;
              phase_next      = lsp_pkg::PH_SKIP;
            end
          end
          lsp_pkg::PH_SKIP: begin
            phase_next = lsp_pkg::PH_DATA;
          end
          lsp_pkg::PH_DATA: begin
            if (character == lsp_pkg::CH_STAR) begin
              if (nibble_pending) begin
                fin        = 1'b1;
                fin_status = lsp_pkg::ST_ODD;
              end else begin
                phase_next = lsp_pkg::PH_CK_HI;
              end
            end else if (!hv.valid) begin
              fin        = 1'b1;
              fin_status = lsp_pkg::ST_BAD_HEX;
            end else if (!nibble_pending) begin
              high_nibble_next    = hv.value;
              nibble_pending_next = 1'b1;
            end else begin
              nibble_pending_next = 1'b0;
              if (byte_count >= lsp_pkg::MAX_DATA_BYTES) begin
                fin        = 1'b1;
                fin_status = lsp_pkg::ST_LONG;
              end else begin
                // Emit the completed data byte
                byte_count_next          = byte_count + 8'd1;
                push                     = 1'b1;
                push_data.kind           = lsp_pkg::KIND_DATA;
                push_data.data_byte      = new_byte;
                push_data.byte_index     = byte_count;
                push_data.time_value     = time_accum;
                push_data.group_number   = group_accum;
                push_data.sender         = sender_reg;
                push_data.payload_length = byte_count + 8'd1;
                push_data.status         = lsp_pkg::ST_OK;
              end
            end
          end
          lsp_pkg::PH_CK_HI: begin
            if (!hv.valid) begin
              fin        = 1'b1;
              fin_status = lsp_pkg::ST_BAD_HEX;
            end else begin
              high_nibble_next = hv.value;
              phase_next       = lsp_pkg::PH_CK_LO;
            end
          end
          lsp_pkg::PH_CK_LO: begin
            fin = 1'b1;
            if (!hv.valid) fin_status = lsp_pkg::ST_BAD_HEX;
            else if (ck_byte != running_xor) fin_status = lsp_pkg::ST_CKSUM;
            else fin_status = lsp_pkg::ST_OK;
          end
          default: begin
            phase_next = lsp_pkg::PH_IDLE;
          end
        endcase
      end

      // Close the line with an end-of-line record
      if (fin) begin
        phase_next               = lsp_pkg::PH_IDLE;
        push                     = 1'b1;
        push_data.kind           = lsp_pkg::KIND_FINAL;
        push_data.time_value     = time_accum;
        push_data.group_number   = group_accum;
        push_data.sender         = sender_reg;
        push_data.payload_length = byte_count;
        push_data.status         = fin_status;
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= lsp_pkg::PH_IDLE;
      time_accum     <= '0;
      group_accum    <= '0;
      sender_reg     <= '0;
      high_nibble    <= '0;
      nibble_pending <= 1'b0;
      byte_count     <= '0;
      running_xor    <= '0;
    end else begin
      phase          <= phase_next;
      time_accum     <= time_accum_next;
      group_accum    <= group_accum_next;
      sender_reg     <= sender_reg_next;
      high_nibble    <= high_nibble_next;
      nibble_pending <= nibble_pending_next;
      byte_count     <= byte_count_next;
      running_xor    <= running_xor_next;
    end
  end

endmodule

@@ rtl/core/lsp_queue.sv @@
// ------------------------------------------------------------------------
// lsp_queue
// Short result queue between the parser and the output stage.
// ------------------------------------------------------------------------
module lsp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lsp_pkg::result_t   push_data,
  input  logic               pop,
  output lsp_pkg::result_t   pop_data,
  output lsp_pkg::q_status_t q_stat
);

  localparam int CNT_W = lsp_pkg::QPTR_W + 1;

  lsp_pkg::result_t            mem [lsp_pkg::QUEUE_DEPTH];
  logic [lsp_pkg::QPTR_W-1:0]  wr_ptr;
  logic [lsp_pkg::QPTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]            count;

  assign q_stat.full  = (count == CNT_W'(lsp_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign pop_data     = mem[rd_ptr];

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/lsp_back.sv @@
// ------------------------------------------------------------------------
// lsp_back
// Output stage: takes results from the queue into a register and packs
// them onto the master stream.
// ------------------------------------------------------------------------
module lsp_back (
  input  logic               clk,
  input  logic               rst,
  input  lsp_pkg::q_status_t q_stat,
  input  lsp_pkg::result_t   pop_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [103:0]       out_data,
  output logic               out_user
);

  lsp_pkg::result_t held;

  // Refill the output register whenever it is empty or being drained
  assign pop = !q_stat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) held <= pop_data;
  end

  // Pack fields, lowest first
  assign out_data = {5'd0, held.status, held.payload_length, held.sender,
                     held.group_number, held.time_value, held.byte_index,
                     held.data_byte};
  assign out_user = held.kind;

endmodule
